// ----- src/vector3_alu_top_macros.svh -----
// assertion macros for the vector unit checker
`ifndef VECTOR3_ALU_TOP_MACROS_SVH
`define VECTOR3_ALU_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define V3A_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vector3_alu check failed");

// next-cycle implication, quiet during reset
`define V3A_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vector3_alu check failed");

`endif

// ----- src/v3a_pkg.sv -----
// shared constants, types and helpers of the vector unit
`timescale 1ns / 1ps
`default_nettype none
package v3a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int SQ_STAGES = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_NEG  = 4'd2,
        OP_SCL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_DOT  = 4'd5,
        OP_CRS  = 4'd6,
        OP_LEN  = 4'd7,
        OP_NRM  = 4'd8,
        OP_CMP  = 4'd9
    } t_op;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [2:0][31:0] vec;
        logic [31:0]      sc;
        logic             eq;
        logic             err;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [2:0][31:0] a;
        logic [31:0]      s;
    } t_mid;

    // clamp a signed 64-bit value to the signed 32-bit range
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [32:0] hi;
        hi = v[63:31];
        if (hi == '0 || hi == '1) begin
            return v[31:0];
        end
        return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage
`default_nettype wire

// ----- src/v3a_lane.sv -----
// one component lane: products, linear ops and the per-component vector result
`timescale 1ns / 1ps
`default_nettype none
module v3a_lane import v3a_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_op                i_op,
    input  wire logic signed [31:0] i_a_i,
    input  wire logic signed [31:0] i_a_j,
    input  wire logic signed [31:0] i_a_k,
    input  wire logic signed [31:0] i_b_i,
    input  wire logic signed [31:0] i_b_j,
    input  wire logic signed [31:0] i_b_k,
    input  wire logic signed [31:0] i_s,
    output logic [31:0]             o_vec,
    output logic signed [63:0]      o_term,
    output logic [63:0]             o_sq
);

    logic signed [31:0] w_m1a, w_m1b;
    logic signed [63:0] w_m1, w_m2;
    logic signed [32:0] w_lin;
    logic signed [63:0] r_p1, r_p2;
    logic signed [32:0] r_lin;
    t_op                r_op;
    logic signed [63:0] w_t1, w_t2;

    always_comb begin
        w_m1a = i_a_i;
        w_m1b = i_b_i;
        case (i_op)
            OP_SCL:  w_m1b = i_s;
            OP_LEN,
            OP_NRM:  w_m1b = i_a_i;
            OP_CRS: begin
                w_m1a = i_a_j;
                w_m1b = i_b_k;
            end
            default: w_m1b = i_b_i;
        endcase
        case (i_op)
            OP_SUB:  w_lin = {i_a_i[31], i_a_i} - {i_b_i[31], i_b_i};
            OP_NEG:  w_lin = -{i_a_i[31], i_a_i};
            default: w_lin = {i_a_i[31], i_a_i} + {i_b_i[31], i_b_i};
        endcase
    end

    assign w_m1 = w_m1a * w_m1b;
    assign w_m2 = i_a_k * i_b_j;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= w_m1;
            r_p2  <= w_m2;
            r_lin <= w_lin;
            r_op  <= i_op;
        end
    end

    // floor shift of the products
    assign w_t1 = r_p1 >>> FRAC_BITS;
    assign w_t2 = r_p2 >>> FRAC_BITS;

    always_comb begin
        case (r_op)
            OP_ADD,
            OP_SUB,
            OP_NEG:  o_vec = sat64({{31{r_lin[32]}}, r_lin});
            OP_SCL:  o_vec = sat64(w_t1);
            OP_CRS:  o_vec = sat64(w_t1 - w_t2);
            default: o_vec = '0;
        endcase
    end

    assign o_term = w_t1;
    assign o_sq   = r_p1;

endmodule
`default_nettype wire

// ----- src/v3a_sqrt.sv -----
// pipelined integer square root, two radicand bits per stage
`timescale 1ns / 1ps
`default_nettype none
module v3a_sqrt import v3a_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_n,
    output logic [31:0]      o_root
);

    logic [35:0] r_rem  [SQ_STAGES];
    logic [31:0] r_root [SQ_STAGES];
    logic [63:0] r_n    [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        logic [35:0] rem, cur, trial;
        logic [31:0] root;
        logic [63:0] n;
        if (i_en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                if (k == 0) begin
                    rem  = '0;
                    root = '0;
                    n    = i_n;
                end else begin
                    rem  = r_rem[k-1];
                    root = r_root[k-1];
                    n    = r_n[k-1];
                end
                cur   = {rem[33:0], n[63:62]};
                trial = {2'b00, root, 2'b01};
                if (cur >= trial) begin
                    r_rem[k]  <= cur - trial;
                    r_root[k] <= {root[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur;
                    r_root[k] <= {root[30:0], 1'b0};
                end
                r_n[k] <= {n[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule
`default_nettype wire

// ----- src/v3a_div.sv -----
// pipelined restoring divider for one lane, saturated signed quotient
`timescale 1ns / 1ps
`default_nettype none
module v3a_div import v3a_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_mag,
    input  wire logic [31:0] i_den,
    input  wire logic        i_neg,
    output logic [31:0]      o_q
);

    logic [31:0]      r_rem [DIV_W];
    logic [DIV_W-1:0] r_q   [DIV_W];
    logic [31:0]      r_den [DIV_W];
    logic             r_neg [DIV_W];
    logic [DIV_W-1:0] w_q;

    always_ff @(posedge i_clk) begin
        logic [31:0]      rem, den;
        logic [DIV_W-1:0] q;
        logic             ng;
        logic [32:0]      trial;
        if (i_en) begin
            for (int k = 0; k < DIV_W; k++) begin
                if (k == 0) begin
                    rem = '0;
                    q   = {i_mag, {FRAC_BITS{1'b0}}};
                    den = i_den;
                    ng  = i_neg;
                end else begin
                    rem = r_rem[k-1];
                    q   = r_q[k-1];
                    den = r_den[k-1];
                    ng  = r_neg[k-1];
                end
                trial = {rem, q[DIV_W-1]};
                if (trial >= {1'b0, den}) begin
                    r_rem[k] <= 32'(trial - {1'b0, den});
                    r_q[k]   <= {q[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[31:0];
                    r_q[k]   <= {q[DIV_W-2:0], 1'b0};
                end
                r_den[k] <= den;
                r_neg[k] <= ng;
            end
        end
    end

    assign w_q = r_q[DIV_W-1];

    always_comb begin
        if (r_neg[DIV_W-1]) begin
            if ((|w_q[DIV_W-1:32]) || (w_q[31] && (|w_q[30:0]))) begin
                o_q = 32'h8000_0000;
            end else begin
                o_q = -w_q[31:0];
            end
        end else begin
            if (|w_q[DIV_W-1:31]) begin
                o_q = 32'h7FFF_FFFF;
            end else begin
                o_q = w_q[31:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/vector3_alu_top.sv -----
// top level of the three-component fixed-point vector unit
//
//  channel   direction  handshake          beat contents
//  input     in         i_valid / o_stall  operation, vectors a and b, scalar
//  result    out        o_valid / i_stall  vector r, scalar, equal, error
//
// one beat enters per cycle while o_stall is low; a result appears after its
// beat is taken once it has passed the input stage, the 32 root stages, the
// divider stages and the output register
// the latency is set by the root pipeline and the one-bit-per-stage divider
// all operations share the same path, so results leave in order
// i_stall freezes the whole pipe only while a finished result is held
// synchronous active-low reset clears the pipeline valid flags
`timescale 1ns / 1ps
`default_nettype none
module vector3_alu_top import v3a_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_operation,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_scalar_in,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_r_x,
    output logic signed [31:0]      o_r_y,
    output logic signed [31:0]      o_r_z,
    output logic signed [31:0]      o_scalar_out,
    output logic                    o_equal,
    output logic                    o_error
);

    // magnitude of a signed word, minimum value included
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    t_op                w_op;
    logic               w_adv;
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic [31:0]        w_vec  [3];
    logic signed [63:0] w_term [3];
    logic [63:0]        w_sq   [3];
    logic [63:0]        w_sqsum;
    logic [31:0]        w_root;
    logic [31:0]        w_den;
    logic [31:0]        w_mag [3];
    logic               w_neg [3];
    logic [31:0]        w_q   [3];
    t_mid               w_mid_b;
    t_mid               w_last;
    t_ctl               w_ctl_c;
    t_ctl               w_ctl_o;

    t_mid               r_sa;
    t_mid               r_sqp [SQ_STAGES];
    t_ctl               r_dvp [DIV_W];
    t_ctl               r_out;

    assign w_op  = t_op'(i_operation);
    // the pipe moves unless a held result is being refused
    assign w_adv = !(r_out.valid && i_stall);
    assign o_stall = !w_adv;

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;

    // stage a: side information captured next to the lane products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
        end else if (w_adv) begin
            r_sa.ctl.valid <= i_valid;
            r_sa.ctl.op    <= w_op;
            r_sa.ctl.vec   <= '0;
            r_sa.ctl.sc    <= '0;
            r_sa.ctl.eq    <= (w_op == OP_CMP) && (i_a_x == i_b_x)
                              && (i_a_y == i_b_y) && (i_a_z == i_b_z);
            r_sa.ctl.err   <= (w_op == OP_DIV) && (i_scalar_in == '0);
            r_sa.a         <= {i_a_z, i_a_y, i_a_x};
            r_sa.s         <= i_scalar_in;
        end
    end

    // three component lanes, each with its own cross-product pair
    for (genvar li = 0; li < 3; li++) begin : g_lane
        v3a_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_op   (w_op),
            .i_a_i  (w_a[li]),
            .i_a_j  (w_a[(li+1)%3]),
            .i_a_k  (w_a[(li+2)%3]),
            .i_b_i  (w_b[li]),
            .i_b_j  (w_b[(li+1)%3]),
            .i_b_k  (w_b[(li+2)%3]),
            .i_s    (i_scalar_in),
            .o_vec  (w_vec[li]),
            .o_term (w_term[li]),
            .o_sq   (w_sq[li])
        );
    end

    // merge: lane vectors, dot sum and sum of squares
    always_comb begin
        w_mid_b            = r_sa;
        w_mid_b.ctl.vec[0] = w_vec[0];
        w_mid_b.ctl.vec[1] = w_vec[1];
        w_mid_b.ctl.vec[2] = w_vec[2];
        w_mid_b.ctl.sc     = (r_sa.ctl.op == OP_DOT)
                             ? sat64(w_term[0] + w_term[1] + w_term[2]) : '0;
    end
    assign w_sqsum = w_sq[0] + w_sq[1] + w_sq[2];

    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_n    (w_sqsum),
        .o_root (w_root)
    );

    // side information rides alongside the root stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sqp[k] <= '0;
            end
        end else if (w_adv) begin
            r_sqp[0] <= w_mid_b;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_sqp[k] <= r_sqp[k-1];
            end
        end
    end

    assign w_last = r_sqp[SQ_STAGES-1];

    // length result, zero-vector check, divider operands
    always_comb begin
        w_ctl_c = w_last.ctl;
        if (w_last.ctl.op == OP_LEN) begin
            w_ctl_c.sc = w_root[31] ? 32'h7FFF_FFFF : w_root;
        end
        if (w_last.ctl.op == OP_NRM && w_root == '0) begin
            w_ctl_c.err = 1'b1;
        end
        w_den = (w_last.ctl.op == OP_DIV) ? abs32(w_last.s) : w_root;
        for (int li = 0; li < 3; li++) begin
            w_mag[li] = abs32(w_last.a[li]);
            w_neg[li] = w_last.a[li][31]
                        ^ ((w_last.ctl.op == OP_DIV) && w_last.s[31]);
        end
    end

    for (genvar li = 0; li < 3; li++) begin : g_div
        v3a_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_mag (w_mag[li]),
            .i_den (w_den),
            .i_neg (w_neg[li]),
            .o_q   (w_q[li])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_W; k++) begin
                r_dvp[k] <= '0;
            end
        end else if (w_adv) begin
            r_dvp[0] <= w_ctl_c;
            for (int k = 1; k < DIV_W; k++) begin
                r_dvp[k] <= r_dvp[k-1];
            end
        end
    end

    // quotients replace the vector for divide and normalise
    always_comb begin
        w_ctl_o = r_dvp[DIV_W-1];
        if (w_ctl_o.op == OP_DIV || w_ctl_o.op == OP_NRM) begin
            for (int li = 0; li < 3; li++) begin
                w_ctl_o.vec[li] = w_ctl_o.err ? '0 : w_q[li];
            end
        end
    end

    // output register holds a refused result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (w_adv) begin
            r_out <= w_ctl_o;
        end
    end

    assign o_valid      = r_out.valid;
    assign o_r_x        = r_out.vec[0];
    assign o_r_y        = r_out.vec[1];
    assign o_r_z        = r_out.vec[2];
    assign o_scalar_out = r_out.sc;
    assign o_equal      = r_out.eq;
    assign o_error      = r_out.err;

endmodule
`default_nettype wire

// ----- src/vector3_alu_checker.sv -----
// port-level checks for the vector unit and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_alu_top_macros.svh"
module vector3_alu_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_r_x,
    input wire logic [31:0] o_r_y,
    input wire logic [31:0] o_r_z,
    input wire logic [31:0] o_scalar_out,
    input wire logic        o_equal,
    input wire logic        o_error
);

    // result held while refused
    `V3A_ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid)
    `V3A_ASSERT_NEXT(a_hold_data, o_valid && i_stall, $stable(o_r_x) && $stable(o_scalar_out))
    // input is refused only when a held result is refused
    `V3A_ASSERT(a_stall_src, 1'b1, o_stall == (o_valid && i_stall))
    // an error beat carries a zero vector and no match
    `V3A_ASSERT(a_err_zero, o_valid && o_error, o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && !o_equal)
    // a match beat carries nothing else
    `V3A_ASSERT(a_eq_only, o_valid && o_equal, o_scalar_out == '0 && o_r_x == '0 && !o_error)

endmodule

bind vector3_alu_top vector3_alu_props u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_r_x        (o_r_x),
    .o_r_y        (o_r_y),
    .o_r_z        (o_r_z),
    .o_scalar_out (o_scalar_out),
    .o_equal      (o_equal),
    .o_error      (o_error)
);
`default_nettype wire

// ----- test/vector3_alu_checker.sv -----
// result predictor and scoreboard for the vector unit testbench
`timescale 1ns / 1ps
module vector3_alu_checker import v3a_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_scalar_in,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_r_x,
    input  logic signed [31:0] o_r_y,
    input  logic signed [31:0] o_r_z,
    input  logic signed [31:0] o_scalar_out,
    input  logic               o_equal,
    input  logic               o_error,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct {
        logic signed [31:0] rx, ry, rz, sc;
        logic               eq, err;
    } vec_result_t;

    vec_result_t result_q[$];

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // product rounded toward minus infinity
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // quotient truncated toward zero
    function automatic longint qdiv(input longint a, input longint d);
        return (a * (64'sd1 <<< FRAC_BITS)) / d;
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic vec_result_t predict_result(input logic [3:0] op,
            input longint ax, input longint ay, input longint az,
            input longint bx, input longint by, input longint bz, input longint s);
        vec_result_t r;
        longint x, y, z, so;
        longint unsigned mag;
        x = 0; y = 0; z = 0; so = 0;
        r.eq = 1'b0;
        r.err = 1'b0;
        mag = root64(longint'(ax * ax) + longint'(ay * ay) + longint'(az * az));
        case (op)
            OP_ADD: begin x = ax + bx; y = ay + by; z = az + bz; end
            OP_SUB: begin x = ax - bx; y = ay - by; z = az - bz; end
            OP_NEG: begin x = -ax; y = -ay; z = -az; end
            OP_SCL: begin x = qmul(ax, s); y = qmul(ay, s); z = qmul(az, s); end
            OP_DIV: begin
                if (s == 0) r.err = 1'b1;
                else begin x = qdiv(ax, s); y = qdiv(ay, s); z = qdiv(az, s); end
            end
            OP_DOT: so = qmul(ax, bx) + qmul(ay, by) + qmul(az, bz);
            OP_CRS: begin
                x = qmul(ay, bz) - qmul(az, by);
                y = qmul(az, bx) - qmul(ax, bz);
                z = qmul(ax, by) - qmul(ay, bx);
            end
            OP_LEN: so = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
            OP_NRM: begin
                if (mag == 0) r.err = 1'b1;
                else begin
                    x = qdiv(ax, longint'(mag));
                    y = qdiv(ay, longint'(mag));
                    z = qdiv(az, longint'(mag));
                end
            end
            OP_CMP: r.eq = (ax == bx && ay == by && az == bz);
            default: ;
        endcase
        r.rx = clamp32(x);
        r.ry = clamp32(y);
        r.rz = clamp32(z);
        r.sc = clamp32(so);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge i_clk) begin
        vec_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = result_q.pop_front();
                if (o_r_x !== want.rx) report_mismatch("r_x", o_r_x, want.rx);
                if (o_r_y !== want.ry) report_mismatch("r_y", o_r_y, want.ry);
                if (o_r_z !== want.rz) report_mismatch("r_z", o_r_z, want.rz);
                if (o_scalar_out !== want.sc) report_mismatch("scalar_out", o_scalar_out, want.sc);
                if (o_equal !== want.eq) report_mismatch("equal", o_equal, want.eq);
                if (o_error !== want.err) report_mismatch("error", o_error, want.err);
            end
        end
        if (i_rst_n && i_valid && !o_stall)
            result_q.push_back(predict_result(i_operation, i_a_x, i_a_y, i_a_z,
                                              i_b_x, i_b_y, i_b_z, i_scalar_in));
        outstanding <= result_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top: clock, reset, stimulus and verdict for the vector unit
`timescale 1ns / 1ps
module tb_top;
    import v3a_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [3:0]         i_operation;
    logic signed [31:0] i_a_x, i_a_y, i_a_z;
    logic signed [31:0] i_b_x, i_b_y, i_b_z;
    logic signed [31:0] i_scalar_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_r_x, o_r_y, o_r_z, o_scalar_out;
    logic               o_equal, o_error;
    int                 mismatches, outstanding;
    bit                 calm;   // set for the closing stretch: no idling either side

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    vector3_alu_top DUT (.*);

    vector3_alu_checker u_checker (.*);

    // all inputs known from time zero, reset held low until the stimulus releases it
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_operation <= OP_ADD;
        i_a_x <= '0; i_a_y <= '0; i_a_z <= '0;
        i_b_x <= '0; i_b_y <= '0; i_b_z <= '0;
        i_scalar_in <= '0;
    end

    // one beat on the input channel; entered and left on a rising edge
    // stall is looked at on the falling edge, well clear of the driving edge
    task automatic push_beat(input logic [3:0] op,
            input logic signed [31:0] ax, input logic signed [31:0] ay,
            input logic signed [31:0] az, input logic signed [31:0] bx,
            input logic signed [31:0] by, input logic signed [31:0] bz,
            input logic signed [31:0] s);
        bit taken;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_a_x <= ax; i_a_y <= ay; i_a_z <= az;
        i_b_x <= bx; i_b_y <= by; i_b_z <= bz;
        i_scalar_in <= s;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // sender gap of a random burst length
    task automatic sender_gap();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge i_clk);
    endtask

    // operand mix: whole range, small magnitudes, plus or minus one, and the extremes
    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            3:    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            4:    return $urandom_range(0, 1) ? ONE : -ONE;
            default: begin
                case ($urandom_range(0, 4))
                    0: return MAXV;
                    1: return MINV;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // receiver back-pressure in random bursts, quiet at the end
    initial begin
        @(posedge i_clk);
        while (1) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [3:0] op;
        logic signed [31:0] ax, ay, az, bx, by, bz, s;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every operation, overflow corners, zero divisor, zero vector
        push_beat(OP_ADD, MAXV, MINV, 5, MAXV, MINV, -5, 0);
        push_beat(OP_SUB, MINV, MAXV, 0, MAXV, MINV, 1, 0);
        push_beat(OP_NEG, MINV, MAXV, -1, 0, 0, 0, 0);
        push_beat(OP_SCL, MAXV, MINV, ONE, 0, 0, 0, MAXV);
        push_beat(OP_SCL, -1, 3, MINV, 0, 0, 0, MINV);
        push_beat(OP_DIV, ONE, -ONE, MAXV, 0, 0, 0, 0);
        push_beat(OP_DIV, MINV, MAXV, 7, 0, 0, 0, 1);
        push_beat(OP_DIV, MINV, -3, 7, 0, 0, 0, -1);
        push_beat(OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0);
        push_beat(OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0);
        push_beat(OP_DOT, -1, -1, -1, 1, 1, 1, 0);
        push_beat(OP_CRS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0);
        push_beat(OP_CRS, ONE, 0, 0, 0, ONE, 0, 0);
        push_beat(OP_LEN, MINV, MINV, MINV, 0, 0, 0, 0);
        push_beat(OP_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
        push_beat(OP_LEN, 0, 0, 0, 0, 0, 0, 0);
        push_beat(OP_NRM, 0, 0, 0, 0, 0, 0, 0);
        push_beat(OP_NRM, MINV, MAXV, 1, 0, 0, 0, 0);
        push_beat(OP_NRM, 0, 0, 1, 0, 0, 0, 0);
        push_beat(OP_CMP, MINV, MAXV, 3, MINV, MAXV, 3, 0);
        push_beat(OP_CMP, MINV, MAXV, 3, MINV, MAXV, 2, 0);
        push_beat(4'($urandom_range(10, 15)), MAXV, MAXV, MAXV, 1, 1, 1, 9);
        push_beat(4'($urandom_range(10, 15)), MINV, -1, 1, -1, -1, -1, -1);

        for (int n = 0; n < 1700; n++) begin
            if (n == 1500) calm = 1'b1;
            // hold off once until the pipe has drained completely
            if (n == 700) begin
                i_valid <= 1'b0;
                while (outstanding != 0) @(posedge i_clk);
            end
            if (!calm && $urandom_range(0, 7) == 0) sender_gap();
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            ax = pick_val(); ay = pick_val(); az = pick_val();
            bx = pick_val(); by = pick_val(); bz = pick_val();
            s  = pick_val();
            // equal operands for compare, zero vector for normalise, now and then
            if (op == OP_CMP && $urandom_range(0, 1)) begin
                bx = ax; by = ay; bz = az;
            end
            if (op == OP_NRM && $urandom_range(0, 9) == 0) begin
                ax = 0; ay = 0; az = 0;
            end
            if (op == OP_DIV && $urandom_range(0, 9) == 0) s = 0;
            push_beat(op, ax, ay, az, bx, by, bz, s);
        end
        i_valid <= 1'b0;

        // drain, then idle before the verdict
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/v3a_pkg.sv
src/v3a_lane.sv
src/v3a_sqrt.sv
src/v3a_div.sv
src/vector3_alu_top.sv
src/vector3_alu_checker.sv
test/vector3_alu_checker.sv
test/tb_top.sv
